/* rtl/tccw_pkg.sv */
`default_nettype none

package tccw_pkg;

  // fixed field widths
  localparam int CELL_IDX_W = 11;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = ATTR_W + CHAR_W;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

  // control codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

  // command codes
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FIN
  } tccw_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;         // latch the input beat, launch a cell read
    logic exec;           // commit cursor move and cell write
    logic clr_we;         // clearing pass: zero cell at sweep count
    logic scr_step;       // scroll pass: one copy step
    logic cnt_clr;
    logic cnt_inc;
    logic out_load;       // load the result register
    logic out_from_exec;  // result taken from the exec cycle, not held state
  } tccw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scroll;
    logic clr_last;
    logic scr_last;
  } tccw_status_t;

endpackage

`default_nettype wire

/* rtl/text_console_character_writer_core.sv */
`default_nettype none

// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_ready    in_command, in_char_code, in_cell_index
// out      out  out_valid / out_ready  out_cursor_position, out_cell_value, out_did_scroll
// cfg      in   cfg_valid / cfg_ready  cfg_text_attribute
//
// A put or read beat passes through an accept state, then an exec state that moves the
// cursor and writes or reads the cell store.
// A put that runs past the last row adds a scroll pass that shifts the store up one row
// through the RAM's single read and write port, one cell a cycle, with the bottom row
// filled with blanks, and then a finish state that loads the result.
// After reset a clearing pass zeros ROWS*COLUMNS cells (2000 by default);
// in_ready stays low until it finishes. cfg beats are taken at any time.
// The result sits in an output register; a new beat is accepted while it waits,
// and the next item stalls only at its own finish if the register is still full.

module text_console_character_writer_core #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic                            in_command,
  input  wire logic [tccw_pkg::CHAR_W-1:0]     in_char_code,
  input  wire logic [tccw_pkg::CELL_IDX_W-1:0] in_cell_index,
  // result channel
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [tccw_pkg::CELL_IDX_W-1:0] out_cursor_position,
  output      logic [tccw_pkg::CELL_W-1:0]     out_cell_value,
  output      logic                            out_did_scroll,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [tccw_pkg::ATTR_W-1:0]     cfg_text_attribute
);

  tccw_pkg::tccw_cmd_t    cmd;
  tccw_pkg::tccw_status_t sts;

  // attribute register takes a beat every cycle
  assign cfg_ready = 1'b1;

  // sequencing: clear pass, accept, exec, scroll sweep, result hand-off
  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // cursor, attribute, cell store and result register
  tccw_dp #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_text_attribute (cfg_text_attribute),
    .in_command         (in_command),
    .in_char_code       (in_char_code),
    .in_cell_index      (in_cell_index),
    .out_cursor_position(out_cursor_position),
    .out_cell_value     (out_cell_value),
    .out_did_scroll     (out_did_scroll)
  );

endmodule

`default_nettype wire

/* rtl/tccw_ram.sv */
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/tccw_ctrl.sv */
`default_nettype none

module tccw_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire tccw_pkg::tccw_status_t sts,
  output      tccw_pkg::tccw_cmd_t    cmd
);

  tccw_pkg::tccw_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tccw_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = tccw_pkg::ST_IDLE;
      end
      tccw_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tccw_pkg::ST_EXEC;
      end
      tccw_pkg::ST_EXEC: begin
        if (sts.need_scroll) state_nxt = tccw_pkg::ST_SCROLL;
        else if (slot_free) state_nxt = tccw_pkg::ST_IDLE;
        else state_nxt = tccw_pkg::ST_FIN;
      end
      tccw_pkg::ST_SCROLL: begin
        if (sts.scr_last) state_nxt = tccw_pkg::ST_FIN;
      end
      tccw_pkg::ST_FIN: begin
        if (slot_free) state_nxt = tccw_pkg::ST_IDLE;
      end
      default: state_nxt = tccw_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      tccw_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) cmd.cnt_clr = 1'b1;
        else cmd.cnt_inc = 1'b1;
      end
      tccw_pkg::ST_IDLE: begin
        cmd.accept = in_valid;
      end
      tccw_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_scroll) begin
          cmd.cnt_clr = 1'b1;
        end else if (slot_free) begin
          cmd.out_load      = 1'b1;
          cmd.out_from_exec = 1'b1;
        end
      end
      tccw_pkg::ST_SCROLL: begin
        cmd.scr_step = 1'b1;
        if (sts.scr_last) cmd.cnt_clr = 1'b1;
        else cmd.cnt_inc = 1'b1;
      end
      tccw_pkg::ST_FIN: begin
        cmd.out_load = slot_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tccw_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == tccw_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while held");

  // no beat is taken while the store is being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tccw_pkg::ST_CLEAR || state_r == tccw_pkg::ST_SCROLL) |-> !in_ready)
    else $error("input accepted during sweep");

  // each item commits exactly once
  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tccw_pkg::ST_EXEC |=> state_r != tccw_pkg::ST_EXEC)
    else $error("exec held for more than one cycle");

endmodule

`default_nettype wire

/* rtl/tccw_dp.sv */
`default_nettype none

module tccw_dp #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tccw_pkg::tccw_cmd_t               cmd,
  output      tccw_pkg::tccw_status_t            sts,
  input  wire logic                              cfg_we,
  input  wire logic [tccw_pkg::ATTR_W-1:0]       cfg_text_attribute,
  input  wire logic                              in_command,
  input  wire logic [tccw_pkg::CHAR_W-1:0]       in_char_code,
  input  wire logic [tccw_pkg::CELL_IDX_W-1:0]   in_cell_index,
  output      logic [tccw_pkg::CELL_IDX_W-1:0]   out_cursor_position,
  output      logic [tccw_pkg::CELL_W-1:0]       out_cell_value,
  output      logic                              out_did_scroll
);

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int COLT_W  = $clog2(COLUMNS + TAB_WIDTH);
  localparam int ROW_W   = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int ROWT_W  = ROW_W + 1;
  localparam int PH_W    = $clog2(TAB_WIDTH + 1);
  localparam int LAST_PH = (COLUMNS - 1) % TAB_WIDTH;
  localparam int IDX_W   = tccw_pkg::CELL_IDX_W;
  localparam int CELL_W  = tccw_pkg::CELL_W;
  localparam int CHAR_W  = tccw_pkg::CHAR_W;
  localparam int ATTR_W  = tccw_pkg::ATTR_W;

  // configuration
  logic [ATTR_W-1:0] attr_r;

  // latched item
  logic              cmd_r;
  logic [CHAR_W-1:0] code_r;
  logic              idx_ok_r;
  logic              idx_ok;

  // cursor and tab phase (column mod tab width)
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PH_W-1:0]   ph_r, ph_nxt, ph_inc, ph_dec;
  logic              scr_r;

  logic [CNT_W-1:0]  cnt_r;

  logic [COLT_W-1:0] col_t;
  logic [ROWT_W-1:0] row_t;
  logic              wrap_scroll;
  logic              put_we;
  logic [ADDR_W-1:0] put_addr;
  logic [CELL_W-1:0] put_data;
  logic [CELL_W-1:0] blank;
  logic [ADDR_W-1:0] cur_addr;

  // memory port
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  logic [CELL_W-1:0] read_value;
  logic [ADDR_W-1:0] lin_nxt, lin_cur;

  assign blank    = {attr_r, {CHAR_W{1'b0}}};
  assign cur_addr = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign idx_ok   = ({{(32 - IDX_W){1'b0}}, in_cell_index} < 32'(CELLS));

  assign ph_inc = (ph_r == PH_W'(TAB_WIDTH - 1)) ? '0 : ph_r + 1'b1;
  assign ph_dec = (ph_r == '0) ? PH_W'(TAB_WIDTH - 1) : ph_r - 1'b1;

  // cursor move for a put
  always_comb begin
    col_t    = COLT_W'(col_r);
    row_t    = ROWT_W'(row_r);
    ph_nxt   = ph_r;
    put_we   = 1'b0;
    put_addr = cur_addr;
    put_data = {attr_r, code_r};
    unique case (code_r)
      tccw_pkg::CH_NEWLINE: begin
        row_t  = row_t + 1'b1;
        col_t  = '0;
        ph_nxt = '0;
      end
      tccw_pkg::CH_RETURN: begin
        col_t  = '0;
        ph_nxt = '0;
      end
      tccw_pkg::CH_BACKSPACE: begin
        // previous cell is linear address minus one, also across rows
        if (cur_addr != '0) begin
          put_we   = 1'b1;
          put_addr = cur_addr - 1'b1;
          put_data = blank;
          if (col_r != '0) begin
            col_t  = col_t - 1'b1;
            ph_nxt = ph_dec;
          end else begin
            row_t  = row_t - 1'b1;
            col_t  = COLT_W'(COLUMNS - 1);
            ph_nxt = PH_W'(LAST_PH);
          end
        end
      end
      tccw_pkg::CH_TAB: begin
        col_t  = col_t + COLT_W'(TAB_WIDTH) - COLT_W'(ph_r);
        ph_nxt = '0;
      end
      default: begin
        put_we = 1'b1;
        col_t  = col_t + 1'b1;
        ph_nxt = ph_inc;
      end
    endcase
    if (col_t >= COLT_W'(COLUMNS)) begin
      col_t  = '0;
      row_t  = row_t + 1'b1;
      ph_nxt = '0;
    end
    wrap_scroll = 1'b0;
    if (row_t >= ROWT_W'(ROWS)) begin
      row_t       = ROWT_W'(ROWS - 1);
      wrap_scroll = 1'b1;
    end
    col_nxt = col_t[COL_W-1:0];
    row_nxt = row_t[ROW_W-1:0];
  end

  assign sts.need_scroll = cmd.exec && (cmd_r == tccw_pkg::CMD_PUT) && wrap_scroll;
  assign sts.clr_last    = (cnt_r == CNT_W'(CELLS - 1));
  assign sts.scr_last    = (cnt_r == CNT_W'(CELLS));

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = put_data;
    mem_re    = 1'b0;
    mem_raddr = ADDR_W'(in_cell_index);
    priority if (cmd.clr_we) begin
      mem_we    = 1'b1;
      mem_waddr = ADDR_W'(cnt_r);
      mem_wdata = '0;
    end else if (cmd.scr_step) begin
      // read row below at count, write one behind it
      mem_re    = (cnt_r < CNT_W'(CELLS - COLUMNS));
      mem_raddr = ADDR_W'(cnt_r + CNT_W'(COLUMNS));
      mem_we    = (cnt_r != '0);
      mem_waddr = ADDR_W'(cnt_r - 1'b1);
      mem_wdata = (cnt_r <= CNT_W'(CELLS - COLUMNS)) ? mem_rdata : blank;
    end else if (cmd.exec) begin
      mem_we    = (cmd_r == tccw_pkg::CMD_PUT) && put_we;
      mem_waddr = put_addr;
      mem_wdata = put_data;
    end else begin
      mem_re = cmd.accept && idx_ok;
    end
  end

  tccw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign read_value = (cmd_r == tccw_pkg::CMD_READ && idx_ok_r) ? mem_rdata : '0;
  assign lin_cur    = cur_addr;
  assign lin_nxt    = (cmd_r == tccw_pkg::CMD_PUT)
                    ? ADDR_W'(row_nxt) * ADDR_W'(COLUMNS) + ADDR_W'(col_nxt)
                    : cur_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tccw_pkg::ATTR_RESET;
      col_r  <= '0;
      row_r  <= '0;
      ph_r   <= '0;
      cnt_r  <= '0;
    end else begin
      if (cfg_we) attr_r <= cfg_text_attribute;
      if (cmd.exec && cmd_r == tccw_pkg::CMD_PUT) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        ph_r  <= ph_nxt;
      end
      if (cmd.cnt_clr) cnt_r <= '0;
      else if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r    <= in_command;
      code_r   <= in_char_code;
      idx_ok_r <= idx_ok;
    end
    if (cmd.exec) begin
      scr_r <= sts.need_scroll;
    end
    if (cmd.out_load) begin
      out_cell_value <= read_value;
      if (cmd.out_from_exec) begin
        out_cursor_position <= IDX_W'(lin_nxt);
        out_did_scroll      <= 1'b0;
      end else begin
        out_cursor_position <= IDX_W'(lin_cur);
        out_did_scroll      <= scr_r;
      end
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(col_r) < COLUMNS) && (int'(row_r) < ROWS))
    else $error("cursor outside the screen");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(ph_r) < TAB_WIDTH)
    else $error("tab phase out of range");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (int'(mem_waddr) < CELLS))
    else $error("cell write beyond store");

endmodule

`default_nettype wire

/* test/tb.sv */
localparam int CON_COLS  = 80;
localparam int CON_ROWS  = 25;
localparam int CON_TAB   = 4;
localparam int CON_CELLS = CON_COLS * CON_ROWS;

typedef struct packed {
  logic [tccw_pkg::CELL_IDX_W-1:0] cursor;
  logic [tccw_pkg::CELL_W-1:0]     cell_val;
  logic                            scrolled;
} console_result_t;

class console_scoreboard;
  logic [tccw_pkg::CELL_W-1:0] cells [CON_CELLS];
  int unsigned                 col;
  int unsigned                 row;
  logic [tccw_pkg::ATTR_W-1:0] attr;
  console_result_t             expected_q [$];
  int unsigned                 mismatches;
  int unsigned                 checked;
  int unsigned                 reads;
  int unsigned                 scrolls;

  function new();
    foreach (cells[i]) cells[i] = '0;
    col        = 0;
    row        = 0;
    attr       = tccw_pkg::ATTR_RESET;
    mismatches = 0;
    checked    = 0;
    reads      = 0;
    scrolls    = 0;
  endfunction

  function void set_attribute(input logic [tccw_pkg::ATTR_W-1:0] a);
    attr = a;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // advance the console copy by one accepted input beat, queue its result
  function void note_beat(input logic cmd, input logic [tccw_pkg::CHAR_W-1:0] code,
                          input logic [tccw_pkg::CELL_IDX_W-1:0] idx);
    console_result_t r;
    int unsigned     i;
    r = '0;
    if (cmd == tccw_pkg::CMD_READ) begin
      if (idx < CON_CELLS) r.cell_val = cells[idx];
      reads++;
    end else begin
      case (code)
        tccw_pkg::CH_NEWLINE: begin
          row++;
          col = 0;
        end
        tccw_pkg::CH_RETURN: col = 0;
        tccw_pkg::CH_BACKSPACE: begin
          if (col > 0) begin
            col--;
            cells[row * CON_COLS + col] = {attr, 8'h00};
          end else if (row > 0) begin
            row--;
            col = CON_COLS - 1;
            cells[row * CON_COLS + col] = {attr, 8'h00};
          end
        end
        tccw_pkg::CH_TAB: col += CON_TAB - (col % CON_TAB);
        default: begin
          cells[row * CON_COLS + col] = {attr, code};
          col++;
        end
      endcase
      if (col > CON_COLS - 1) begin
        col = 0;
        row++;
      end
      if (row > CON_ROWS - 1) begin
        for (i = 0; i < CON_CELLS - CON_COLS; i++) cells[i] = cells[i + CON_COLS];
        for (i = CON_CELLS - CON_COLS; i < CON_CELLS; i++) cells[i] = {attr, 8'h00};
        row = CON_ROWS - 1;
        r.scrolled = 1'b1;
        scrolls++;
      end
    end
    r.cursor = tccw_pkg::CELL_IDX_W'(row * CON_COLS + col);
    expected_q.push_back(r);
  endfunction

  function void check_beat(input logic [tccw_pkg::CELL_IDX_W-1:0] cursor,
                           input logic [tccw_pkg::CELL_W-1:0] cell_val,
                           input logic scrolled, input longint unsigned stamp);
    console_result_t e;
    if (expected_q.size() == 0) begin
      $display("%0d ns: unexpected result beat, expected none, got cursor %0d cell %h scroll %0d",
               stamp, cursor, cell_val, scrolled);
      mismatches++;
      return;
    end
    e = expected_q.pop_front();
    checked++;
    if (cursor !== e.cursor) begin
      $display("%0d ns: cursor_position expected %0d got %0d", stamp, e.cursor, cursor);
      mismatches++;
    end
    if (cell_val !== e.cell_val) begin
      $display("%0d ns: cell_value expected %h got %h", stamp, e.cell_val, cell_val);
      mismatches++;
    end
    if (scrolled !== e.scrolled) begin
      $display("%0d ns: did_scroll expected %0d got %0d", stamp, e.scrolled, scrolled);
      mismatches++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Worst case is every put scrolling plus both sides stalling their longest
  // draw; the limit sits several times above it.
  localparam longint unsigned LIMIT_CYCLES  = 64'd10_000_000;
  // result register plus exec cycle, with margin
  localparam int              SETTLE_CYCLES = 6;
  localparam int              PHASES        = 6;
  localparam int              PHASE_BEATS   = 215;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_command = tccw_pkg::CMD_PUT;
  logic [tccw_pkg::CHAR_W-1:0]     in_char_code = '0;
  logic [tccw_pkg::CELL_IDX_W-1:0] in_cell_index = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [tccw_pkg::CELL_IDX_W-1:0] out_cursor_position;
  logic [tccw_pkg::CELL_W-1:0]     out_cell_value;
  logic                            out_did_scroll;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [tccw_pkg::ATTR_W-1:0]     cfg_text_attribute = '0;

  console_scoreboard sb = new();

  // when set, neither side inserts idle cycles
  logic                  quiet = 1'b0;
  longint unsigned       cycle_count = 0;
  int unsigned           attr_writes = 0;

  // per-phase mix: newline and backspace percentages; a backspace-heavy
  // phase walks the cursor back up across row boundaries
  int unsigned lf_plan [PHASES] = '{6, 8, 2, 10, 4, 6};
  int unsigned bs_plan [PHASES] = '{6, 4, 30, 5, 10, 6};
  logic [tccw_pkg::ATTR_W-1:0] attr_plan [PHASES] =
    '{8'h0F, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h80};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_console_character_writer_core #(
    .COLUMNS   (CON_COLS),
    .ROWS      (CON_ROWS),
    .TAB_WIDTH (CON_TAB)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_char_code        (in_char_code),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cursor_position (out_cursor_position),
    .out_cell_value      (out_cell_value),
    .out_did_scroll      (out_did_scroll),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_text_attribute  (cfg_text_attribute)
  );

  // Watchdog: a hung handshake or a stuck scroll ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("text_console_character_writer_core: mismatch");
      $finish;
    end
  end

  // Send one input beat. A gap is drawn first; valid only drops when the
  // gap is nonzero, so back-to-back beats keep valid high with a new payload.
  // The beat is taken at the first edge that sees in_ready high.
  task automatic send_beat(input logic cmd, input logic [tccw_pkg::CHAR_W-1:0] code,
                           input logic [tccw_pkg::CELL_IDX_W-1:0] idx);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_char_code  <= code;
    in_cell_index <= idx;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(cmd, code, idx);
  endtask

  // One random beat. Reads mostly target the cursor's neighborhood, where the
  // store actually changes; some go anywhere and a few land past the store.
  task automatic send_random(input int unsigned lf_pct, input int unsigned bs_pct);
    int unsigned                     pick;
    int unsigned                     base_row;
    logic [tccw_pkg::CELL_IDX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       idx = tccw_pkg::CELL_IDX_W'($urandom_range(CON_CELLS, 2047));
      1, 2, 3: idx = tccw_pkg::CELL_IDX_W'($urandom_range(0, CON_CELLS - 1));
      default: begin
        base_row = (sb.row > 0 && $urandom_range(0, 2) == 0) ? sb.row - 1 : sb.row;
        idx = tccw_pkg::CELL_IDX_W'(base_row * CON_COLS + $urandom_range(0, CON_COLS - 1));
      end
    endcase
    if (pick < 20)
      send_beat(tccw_pkg::CMD_READ, tccw_pkg::CHAR_W'($urandom), idx);
    else if (pick < 20 + lf_pct)
      send_beat(tccw_pkg::CMD_PUT, tccw_pkg::CH_NEWLINE, tccw_pkg::CELL_IDX_W'($urandom));
    else if (pick < 20 + lf_pct + bs_pct)
      send_beat(tccw_pkg::CMD_PUT, tccw_pkg::CH_BACKSPACE, tccw_pkg::CELL_IDX_W'($urandom));
    else if (pick < 26 + lf_pct + bs_pct)
      send_beat(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, tccw_pkg::CELL_IDX_W'($urandom));
    else if (pick < 29 + lf_pct + bs_pct)
      send_beat(tccw_pkg::CMD_PUT, tccw_pkg::CH_RETURN, tccw_pkg::CELL_IDX_W'($urandom));
    else
      send_beat(tccw_pkg::CMD_PUT, tccw_pkg::CHAR_W'($urandom),
                tccw_pkg::CELL_IDX_W'($urandom));
  endtask

  // Hold the sender until every queued result has come back, then let the
  // block settle so no scroll or exec cycle is still in flight.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [tccw_pkg::ATTR_W-1:0] a);
    cfg_valid          <= 1'b1;
    cfg_text_attribute <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_attribute(a);
    attr_writes++;
  endtask

  // Result side: draw a stall per beat, then hold ready until a beat lands
  // and compare it against the oldest expectation.
  initial begin : result_sink
    int unsigned stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_beat(out_cursor_position, out_cell_value, out_did_scroll, $time);
    end
  end

  initial begin : stimulus
    int                          p;
    int                          n;
    logic [tccw_pkg::ATTR_W-1:0] a;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. in_ready stays low through the clearing pass, so the
    // first beat simply waits it out.
    send_beat(tccw_pkg::CMD_READ, 8'h00, 11'd0);              // cleared cell reads zero
    send_beat(tccw_pkg::CMD_READ, 8'hFF, 11'd2047);           // past the store: zero
    send_beat(tccw_pkg::CMD_PUT, tccw_pkg::CH_BACKSPACE, 11'd0); // backspace at origin: no-op
    send_beat(tccw_pkg::CMD_PUT, 8'h41, 11'd2047);
    send_beat(tccw_pkg::CMD_PUT, 8'h00, 11'd0);               // NUL is printed like any byte
    send_beat(tccw_pkg::CMD_PUT, 8'hFF, 11'd0);               // top byte stays unsigned
    send_beat(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, 11'd0);    // col 3 -> 4
    send_beat(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, 11'd0);    // already aligned: 4 -> 8
    send_beat(tccw_pkg::CMD_PUT, tccw_pkg::CH_RETURN, 11'd0);
    send_beat(tccw_pkg::CMD_READ, 8'h00, 11'd0);
    send_beat(tccw_pkg::CMD_READ, 8'h00, 11'd2);
    send_beat(tccw_pkg::CMD_PUT, tccw_pkg::CH_NEWLINE, 11'd0);
    send_beat(tccw_pkg::CMD_PUT, tccw_pkg::CH_BACKSPACE, 11'd0); // col 0 -> previous row, col 79
    send_beat(tccw_pkg::CMD_READ, 8'h00, 11'd79);             // blanked cell
    send_beat(tccw_pkg::CMD_PUT, 8'h7E, 11'd0);               // last column wraps to next row
    send_beat(tccw_pkg::CMD_READ, 8'h00, 11'd79);
    send_beat(tccw_pkg::CMD_READ, 8'h00, 11'd1999);           // last cell of the store
    send_beat(tccw_pkg::CMD_READ, 8'h00, 11'd2000);           // first address past it
    send_beat(tccw_pkg::CMD_READ, 8'h00, 11'd1024);
    send_beat(tccw_pkg::CMD_PUT, tccw_pkg::CH_NEWLINE, 11'd0);

    // Random phases, each under its own attribute. Every fifth stretch of 40
    // beats runs with no idling, and one phase runs flat out throughout.
    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        a = (p == 3 || p == 4) ? tccw_pkg::ATTR_W'($urandom) : attr_plan[p];
        write_attribute(a);
      end
      for (n = 0; n < PHASE_BEATS; n++) begin
        quiet = (p == 3) || ((n / 40) % 5 == 4);
        send_random(lf_plan[p], bs_plan[p]);
      end
      quiet = 1'b0;
    end

    drain_results();
    $display("%0d result beats checked: %0d reads, %0d scrolls, %0d attribute writes",
             sb.checked, sb.reads, sb.scrolls, attr_writes);
    if (sb.mismatches == 0)
      $display("text_console_character_writer_core: match");
    else
      $display("text_console_character_writer_core: mismatch");
    $finish;
  end
endmodule

/* text_console_character_writer_core.f */
rtl/tccw_pkg.sv
rtl/tccw_ram.sv
rtl/tccw_ctrl.sv
rtl/tccw_dp.sv
rtl/text_console_character_writer_core.sv
test/tb.sv
